// ===== src/scf_pkg.sv =====
// ----------------------------------------------------------------------------
// scf_pkg
// Types and constants shared by the source character filter.
// ----------------------------------------------------------------------------
package scf_pkg;

  // Field widths fixed by the interface
  localparam int BYTE_W = 8;
  localparam int LINE_W = 24;
  localparam int MAX_RES = 3;
  localparam int RES_IDX_W = 2;

  // Character codes of interest
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;

  // Comment scanner phase: 2 is the idle phase inside a comment body,
  // 0 means a closing star-slash has just completed one level.
  localparam logic [1:0] PH_CLOSE = 2'd0;
  localparam logic [1:0] PH_BODY  = 2'd2;

  localparam logic [1:0] ON_OTHER [4] = '{2'd0, 2'd0, 2'd2, 2'd2};
  localparam logic [1:0] ON_STAR  [4] = '{2'd0, 2'd2, 2'd3, 2'd3};
  localparam logic [1:0] ON_SLASH [4] = '{2'd1, 2'd1, 2'd1, 2'd0};

  // Input request
  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              end_of_input;
  } in_item_t;

  // Result request
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              is_end;
    logic              blank_before;
    logic              comment_before;
    logic [LINE_W-1:0] line_number;
    logic              comment_error;
    logic              last_of_run;
  } out_item_t;

endpackage

// ===== src/source_char_filter_nested_comments_core.sv =====
// ----------------------------------------------------------------------------
// source_char_filter_nested_comments_core
// Filters raw source bytes into relevant characters with nested comments.
// ----------------------------------------------------------------------------
// One source byte is taken per request on the input channel. The byte is
// decoded combinationally against the filter state (pending comma, held
// slash, comment nesting, flags, line counter) and the zero to three result
// requests it causes are written into a three-entry result buffer, which
// drains one request per cycle on the output channel while out_ready is
// high. Ordinary text streams at one byte per clock while the output is
// ready; a byte that yields several results holds off the next byte while
// the buffer drains. The next byte is taken in the same cycle as the last
// buffered result leaves. Space, tab and CR are dropped, comments are
// skipped, and a comma continued to the next line is folded into a blank.
// Line numbers and nesting depth saturate.
// ----------------------------------------------------------------------------
module source_char_filter_nested_comments_core #(
  parameter int DEPTH_BITS = 8,
  parameter int LINE_BITS  = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  scf_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output scf_pkg::out_item_t  out_data
);

  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0]  LINE_MAX  = {LINE_BITS{1'b1}};

  // Filter state
  logic                  comma_pending_r, comma_pending_nxt;
  logic                  slash_held_r, slash_held_nxt;
  logic                  in_comment_r, in_comment_nxt;
  logic [1:0]            comment_phase_r, comment_phase_nxt;
  logic [DEPTH_BITS-1:0] nest_depth_r, nest_depth_nxt;
  logic                  blank_seen_r, blank_seen_nxt;
  logic                  comment_seen_r, comment_seen_nxt;
  logic                  la_blank_r, la_blank_nxt;
  logic                  la_comment_r, la_comment_nxt;
  logic [LINE_BITS-1:0]  line_count_r, line_count_nxt;

  // Result buffer
  scf_pkg::out_item_t    res_r [scf_pkg::MAX_RES];
  scf_pkg::out_item_t    res_nxt [scf_pkg::MAX_RES];
  logic [scf_pkg::RES_IDX_W-1:0] cnt_r, n_nxt;

  logic in_acc, out_acc;

  assign out_valid = (cnt_r != '0);
  assign out_data  = res_r[0];
  assign out_acc   = out_valid && out_ready;
  assign in_ready  = (cnt_r == '0) || ((cnt_r == scf_pkg::RES_IDX_W'(1)) && out_ready);
  assign in_acc    = in_valid && in_ready;

  // Build one result from the current flags
  function automatic scf_pkg::out_item_t mk_res(
    input logic [scf_pkg::BYTE_W-1:0] b,
    input logic                       e,
    input logic                       bl,
    input logic                       cm,
    input logic [LINE_BITS-1:0]       ln,
    input logic                       err
  );
    scf_pkg::out_item_t r;
    r.out_byte       = b;
    r.is_end         = e;
    r.blank_before   = bl;
    r.comment_before = cm;
    r.line_number    = scf_pkg::LINE_W'(ln);
    r.comment_error  = err;
    r.last_of_run    = 1'b0;
    return r;
  endfunction

  // Single-pass decode of one byte
  always_comb begin
    logic [scf_pkg::BYTE_W-1:0] c;
    logic                       do_plain;
    logic [1:0]                 st;
    logic                       err;

    c        = in_data.in_byte;
    do_plain = 1'b0;
    err      = 1'b0;
    st       = comment_phase_r;

    comma_pending_nxt = comma_pending_r;
    slash_held_nxt    = slash_held_r;
    in_comment_nxt    = in_comment_r;
    comment_phase_nxt = comment_phase_r;
    nest_depth_nxt    = nest_depth_r;
    blank_seen_nxt    = blank_seen_r;
    comment_seen_nxt  = comment_seen_r;
    la_blank_nxt      = la_blank_r;
    la_comment_nxt    = la_comment_r;
    line_count_nxt    = line_count_r;
    n_nxt             = '0;
    for (int i = 0; i < scf_pkg::MAX_RES; i++) begin
      res_nxt[i] = '0;
    end

    if (in_data.end_of_input) begin
      // End of input: close any comment, flush comma and slash, then marker
      err               = in_comment_r;
      in_comment_nxt    = 1'b0;
      comment_phase_nxt = scf_pkg::PH_BODY;
      nest_depth_nxt    = '0;
      if (comma_pending_nxt) begin
        res_nxt[n_nxt] = mk_res(scf_pkg::CH_COMMA, 1'b0, blank_seen_nxt,
                                comment_seen_nxt, line_count_nxt, 1'b0);
        n_nxt             = n_nxt + 1'b1;
        blank_seen_nxt    = la_blank_nxt;
        comment_seen_nxt  = la_comment_nxt;
        la_blank_nxt      = 1'b0;
        la_comment_nxt    = 1'b0;
        comma_pending_nxt = 1'b0;
      end
      if (slash_held_nxt) begin
        res_nxt[n_nxt] = mk_res(scf_pkg::CH_SLASH, 1'b0, blank_seen_nxt,
                                comment_seen_nxt, line_count_nxt, 1'b0);
        n_nxt            = n_nxt + 1'b1;
        blank_seen_nxt   = 1'b0;
        comment_seen_nxt = 1'b0;
        slash_held_nxt   = 1'b0;
      end
      res_nxt[n_nxt] = mk_res(scf_pkg::CH_NUL, 1'b1, blank_seen_nxt,
                              comment_seen_nxt, line_count_nxt, err);
      n_nxt            = n_nxt + 1'b1;
      blank_seen_nxt   = 1'b0;
      comment_seen_nxt = 1'b0;
    end else if (in_comment_r) begin
      // Inside a comment: step the phase table, track nesting
      if (c == scf_pkg::CH_STAR) begin
        st = scf_pkg::ON_STAR[st];
      end else if (c == scf_pkg::CH_SLASH) begin
        if ((st == scf_pkg::PH_BODY) && (nest_depth_r != DEPTH_MAX)) begin
          nest_depth_nxt = nest_depth_r + 1'b1;
        end
        st = scf_pkg::ON_SLASH[st];
      end else begin
        if ((c == scf_pkg::CH_LF) && (line_count_r != LINE_MAX)) begin
          line_count_nxt = line_count_r + 1'b1;
        end
        st = scf_pkg::ON_OTHER[st];
      end
      if (st == scf_pkg::PH_CLOSE) begin
        if (nest_depth_nxt == '0) begin
          in_comment_nxt = 1'b0;
        end else begin
          nest_depth_nxt = nest_depth_nxt - 1'b1;
        end
        st = scf_pkg::PH_BODY;
      end
      comment_phase_nxt = st;
    end else if (slash_held_r) begin
      // Held slash resolves: comment opener or a plain slash
      slash_held_nxt = 1'b0;
      if (c == scf_pkg::CH_STAR) begin
        in_comment_nxt    = 1'b1;
        comment_phase_nxt = scf_pkg::PH_BODY;
        nest_depth_nxt    = '0;
        if (comma_pending_r) begin
          la_comment_nxt = 1'b1;
        end else begin
          comment_seen_nxt = 1'b1;
        end
      end else begin
        if (comma_pending_nxt) begin
          res_nxt[n_nxt] = mk_res(scf_pkg::CH_COMMA, 1'b0, blank_seen_nxt,
                                  comment_seen_nxt, line_count_nxt, 1'b0);
          n_nxt             = n_nxt + 1'b1;
          blank_seen_nxt    = la_blank_nxt;
          comment_seen_nxt  = la_comment_nxt;
          la_blank_nxt      = 1'b0;
          la_comment_nxt    = 1'b0;
          comma_pending_nxt = 1'b0;
        end
        res_nxt[n_nxt] = mk_res(scf_pkg::CH_SLASH, 1'b0, blank_seen_nxt,
                                comment_seen_nxt, line_count_nxt, 1'b0);
        n_nxt            = n_nxt + 1'b1;
        blank_seen_nxt   = 1'b0;
        comment_seen_nxt = 1'b0;
        do_plain         = 1'b1;
      end
    end else begin
      do_plain = 1'b1;
    end

    // Ordinary byte outside a comment
    if (do_plain) begin
      case (c)
        scf_pkg::CH_SPACE, scf_pkg::CH_TAB: begin
          if (comma_pending_nxt) begin
            la_blank_nxt = 1'b1;
          end else begin
            blank_seen_nxt = 1'b1;
          end
        end
        scf_pkg::CH_CR: begin
        end
        scf_pkg::CH_LF: begin
          if (comma_pending_nxt) begin
            // continuation: comma and newline fold into a blank
            comma_pending_nxt = 1'b0;
            la_blank_nxt      = 1'b0;
            la_comment_nxt    = 1'b0;
            blank_seen_nxt    = 1'b1;
          end else begin
            res_nxt[n_nxt] = mk_res(scf_pkg::CH_LF, 1'b0, blank_seen_nxt,
                                    comment_seen_nxt, line_count_nxt, 1'b0);
            n_nxt            = n_nxt + 1'b1;
            blank_seen_nxt   = 1'b0;
            comment_seen_nxt = 1'b0;
          end
          if (line_count_nxt != LINE_MAX) begin
            line_count_nxt = line_count_nxt + 1'b1;
          end
        end
        scf_pkg::CH_COMMA: begin
          if (comma_pending_nxt) begin
            res_nxt[n_nxt] = mk_res(scf_pkg::CH_COMMA, 1'b0, blank_seen_nxt,
                                    comment_seen_nxt, line_count_nxt, 1'b0);
            n_nxt            = n_nxt + 1'b1;
            blank_seen_nxt   = la_blank_nxt;
            comment_seen_nxt = la_comment_nxt;
          end
          comma_pending_nxt = 1'b1;
          la_blank_nxt      = 1'b0;
          la_comment_nxt    = 1'b0;
        end
        scf_pkg::CH_SLASH: begin
          slash_held_nxt = 1'b1;
        end
        default: begin
          if (comma_pending_nxt) begin
            res_nxt[n_nxt] = mk_res(scf_pkg::CH_COMMA, 1'b0, blank_seen_nxt,
                                    comment_seen_nxt, line_count_nxt, 1'b0);
            n_nxt             = n_nxt + 1'b1;
            blank_seen_nxt    = la_blank_nxt;
            comment_seen_nxt  = la_comment_nxt;
            la_blank_nxt      = 1'b0;
            la_comment_nxt    = 1'b0;
            comma_pending_nxt = 1'b0;
          end
          res_nxt[n_nxt] = mk_res(c, 1'b0, blank_seen_nxt, comment_seen_nxt,
                                  line_count_nxt, 1'b0);
          n_nxt            = n_nxt + 1'b1;
          blank_seen_nxt   = 1'b0;
          comment_seen_nxt = 1'b0;
        end
      endcase
    end

    // Mark the final result of this byte
    if (n_nxt != '0) begin
      res_nxt[n_nxt - 1'b1].last_of_run = 1'b1;
    end
  end

  // Filter state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comma_pending_r <= 1'b0;
      slash_held_r    <= 1'b0;
      in_comment_r    <= 1'b0;
      comment_phase_r <= scf_pkg::PH_BODY;
      nest_depth_r    <= '0;
      blank_seen_r    <= 1'b0;
      comment_seen_r  <= 1'b0;
      la_blank_r      <= 1'b0;
      la_comment_r    <= 1'b0;
      line_count_r    <= LINE_BITS'(1);
    end else if (in_acc) begin
      comma_pending_r <= comma_pending_nxt;
      slash_held_r    <= slash_held_nxt;
      in_comment_r    <= in_comment_nxt;
      comment_phase_r <= comment_phase_nxt;
      nest_depth_r    <= nest_depth_nxt;
      blank_seen_r    <= blank_seen_nxt;
      comment_seen_r  <= comment_seen_nxt;
      la_blank_r      <= la_blank_nxt;
      la_comment_r    <= la_comment_nxt;
      line_count_r    <= line_count_nxt;
    end
  end

  // Result buffer count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_acc) begin
      cnt_r <= n_nxt;
    end else if (out_acc) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // Result buffer payload: load on a new byte, shift on each delivery
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < scf_pkg::MAX_RES; i++) begin
        res_r[i] <= res_nxt[i];
      end
    end else if (out_acc) begin
      for (int i = 0; i < scf_pkg::MAX_RES - 1; i++) begin
        res_r[i] <= res_r[i+1];
      end
    end
  end

`ifndef SYNTH
  // Only the final buffered result closes a run
  a_last_only_at_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last_of_run == (cnt_r == scf_pkg::RES_IDX_W'(1))))
    else $error("last_of_run does not match buffer tail");

  // Error flag only travels on the end marker
  a_err_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.comment_error) |-> out_data.is_end)
    else $error("comment_error outside end marker");

  // A new byte is never taken while more than one result is still queued
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ((cnt_r == '0) || (out_acc && (cnt_r == scf_pkg::RES_IDX_W'(1)))))
    else $error("result buffer overrun");

  // Line counter never drops to zero
  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    line_count_r != '0)
    else $error("line counter reached zero");
`endif

endmodule

// ===== dv/tb_source_char_filter_nested_comments_core.sv =====
// ----------------------------------------------------------------------------
// tb_source_char_filter_nested_comments_core
// Self-checking bench for the nested-comment source character filter.
// ----------------------------------------------------------------------------
// A directed opener covers blanks, newlines, extreme byte values, comma
// continuation across a comment, a comma released by a second comma, a held
// slash that yields three results, nesting and an unterminated comment at end
// of input. The bulk is randomised token streams: words, blanks, comments
// with nested openers, commas with look-ahead, stray slashes, raw noise and
// end markers.
// A behavioural filter model predicts every result; the monitor checks each
// field in order. Back-pressure and source gaps vary over three phases, and
// the result side is held off for long stretches to fill the block.
// ----------------------------------------------------------------------------
module tb_source_char_filter_nested_comments_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_ITEMS  = 335;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 90;

  localparam logic [7:0]                 DEPTH_MAX = 8'hFF;
  localparam logic [scf_pkg::LINE_W-1:0] LINE_MAX  = '1;

  // Comment scanner phase tables, entry n in bits [2n+1:2n]
  localparam logic [7:0] AFTER_OTHER = {2'd2, 2'd2, 2'd0, 2'd0};
  localparam logic [7:0] AFTER_STAR  = {2'd3, 2'd3, 2'd2, 2'd0};
  localparam logic [7:0] AFTER_SLASH = {2'd0, 2'd1, 2'd1, 2'd1};

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  scf_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  scf_pkg::out_item_t out_data;

  // Stimulus and expectation stores
  scf_pkg::in_item_t  src_bytes[$];
  scf_pkg::out_item_t expected_chars[$];
  scf_pkg::out_item_t step_chars[$];
  scf_pkg::out_item_t want_char;

  // Filter model state
  logic                       pend_comma;
  logic                       held_slash;
  logic                       in_cmt;
  logic [1:0]                 cmt_phase;
  logic [7:0]                 depth;
  logic                       blank_flag;
  logic                       cmt_flag;
  logic                       la_blank;
  logic                       la_cmt;
  logic [scf_pkg::LINE_W-1:0] line_no;

  // Bookkeeping
  logic in_took = 1'b0;
  int   acc_cnt = 0;
  int   res_cnt = 0;
  int   end_cnt = 0;
  int   err_cnt = 0;
  int   peak_res = 0;
  int   mismatches = 0;
  int   cycle_cnt = 0;
  int   phase1_at = 32'h7fff_ffff;
  int   phase2_at = 32'h7fff_ffff;
  int   hold_left = 0;
  int   holds_done = 0;
  int   rand_start;
  int   pick;

  source_char_filter_nested_comments_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // Filter model
  // ------------------------------------------------------------------------
  task automatic pass_char(input logic [7:0] b, input logic is_eoi, input logic err);
    scf_pkg::out_item_t r;
    if (step_chars.size() >= scf_pkg::MAX_RES) return;
    r.out_byte       = b;
    r.is_end         = is_eoi;
    r.blank_before   = blank_flag;
    r.comment_before = cmt_flag;
    r.line_number    = line_no;
    r.comment_error  = err;
    r.last_of_run    = 1'b0;
    step_chars.push_back(r);
    blank_flag = 1'b0;
    cmt_flag   = 1'b0;
  endtask

  task automatic bump_line();
    if (line_no != LINE_MAX) line_no = line_no + 1'b1;
  endtask

  // A pending comma goes out first; its look-ahead flags carry to the next char
  task automatic release_comma();
    if (!pend_comma) return;
    pass_char(scf_pkg::CH_COMMA, 1'b0, 1'b0);
    blank_flag = la_blank;
    cmt_flag   = la_cmt;
    la_blank   = 1'b0;
    la_cmt     = 1'b0;
    pend_comma = 1'b0;
  endtask

  task automatic scan_comment(input logic [7:0] c);
    logic [1:0] ph;
    ph = cmt_phase;
    if (c == scf_pkg::CH_STAR) begin
      ph = AFTER_STAR[{ph, 1'b0} +: 2];
    end else if (c == scf_pkg::CH_SLASH) begin
      if (ph == scf_pkg::PH_BODY && depth != DEPTH_MAX) depth = depth + 1'b1;
      ph = AFTER_SLASH[{ph, 1'b0} +: 2];
    end else begin
      if (c == scf_pkg::CH_LF) bump_line();
      ph = AFTER_OTHER[{ph, 1'b0} +: 2];
    end
    // one nesting level closed
    if (ph == scf_pkg::PH_CLOSE) begin
      if (depth == '0) in_cmt = 1'b0;
      else depth = depth - 1'b1;
      ph = scf_pkg::PH_BODY;
    end
    cmt_phase = ph;
  endtask

  task automatic plain_char(input logic [7:0] c);
    case (c)
      scf_pkg::CH_SPACE, scf_pkg::CH_TAB: begin
        if (pend_comma) la_blank = 1'b1;
        else blank_flag = 1'b1;
      end
      scf_pkg::CH_CR: ;
      scf_pkg::CH_LF: begin
        if (pend_comma) begin
          // continuation: comma and newline fold into a blank
          pend_comma = 1'b0;
          la_blank   = 1'b0;
          la_cmt     = 1'b0;
          blank_flag = 1'b1;
        end else begin
          pass_char(scf_pkg::CH_LF, 1'b0, 1'b0);
        end
        bump_line();
      end
      scf_pkg::CH_COMMA: begin
        release_comma();
        pend_comma = 1'b1;
        la_blank   = 1'b0;
        la_cmt     = 1'b0;
      end
      scf_pkg::CH_SLASH: held_slash = 1'b1;
      default: begin
        release_comma();
        pass_char(c, 1'b0, 1'b0);
      end
    endcase
  endtask

  task automatic reset_filter();
    pend_comma = 1'b0;
    held_slash = 1'b0;
    in_cmt     = 1'b0;
    cmt_phase  = scf_pkg::PH_BODY;
    depth      = '0;
    blank_flag = 1'b0;
    cmt_flag   = 1'b0;
    la_blank   = 1'b0;
    la_cmt     = 1'b0;
    line_no    = scf_pkg::LINE_W'(1);
  endtask

  // Works out the results of one accepted request and queues them
  task automatic filter_byte(input scf_pkg::in_item_t it);
    logic err;
    step_chars.delete();
    if (it.end_of_input) begin
      err       = in_cmt;
      in_cmt    = 1'b0;
      cmt_phase = scf_pkg::PH_BODY;
      depth     = '0;
      release_comma();
      if (held_slash) begin
        pass_char(scf_pkg::CH_SLASH, 1'b0, 1'b0);
        held_slash = 1'b0;
      end
      pass_char(scf_pkg::CH_NUL, 1'b1, err);
      end_cnt++;
      if (err) err_cnt++;
    end else if (in_cmt) begin
      scan_comment(it.in_byte);
    end else if (held_slash) begin
      held_slash = 1'b0;
      if (it.in_byte == scf_pkg::CH_STAR) begin
        in_cmt    = 1'b1;
        cmt_phase = scf_pkg::PH_BODY;
        depth     = '0;
        if (pend_comma) la_cmt = 1'b1;
        else cmt_flag = 1'b1;
      end else begin
        release_comma();
        pass_char(scf_pkg::CH_SLASH, 1'b0, 1'b0);
        plain_char(it.in_byte);
      end
    end else begin
      plain_char(it.in_byte);
    end
    if (step_chars.size() > 0) step_chars[step_chars.size()-1].last_of_run = 1'b1;
    if (step_chars.size() > peak_res) peak_res = step_chars.size();
    foreach (step_chars[i]) expected_chars.push_back(step_chars[i]);
  endtask

  // ------------------------------------------------------------------------
  // Checking
  // ------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] result %0d mismatch: %s", $time, res_cnt, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // ------------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------------
  task automatic push_item(input logic [7:0] b, input logic eoi = 1'b0);
    scf_pkg::in_item_t it;
    it.in_byte      = b;
    it.end_of_input = eoi;
    src_bytes.push_back(it);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_item(s[i]);
  endtask

  // Any byte with no special meaning outside a comment
  task automatic push_ord();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == scf_pkg::CH_SPACE || b == scf_pkg::CH_TAB || b == scf_pkg::CH_CR ||
        b == scf_pkg::CH_LF || b == scf_pkg::CH_COMMA || b == scf_pkg::CH_SLASH)
      b = 8'h41 + {4'h0, b[3:0]};
    push_item(b);
  endtask

  task automatic push_blank();
    case ($urandom_range(0, 2))
      0: push_item(scf_pkg::CH_SPACE);
      1: push_item(scf_pkg::CH_TAB);
      default: push_item(scf_pkg::CH_CR);
    endcase
  endtask

  task automatic push_comment(input bit closed);
    int n;
    push_text("/*");
    n = $urandom_range(0, 6);
    repeat (n) begin
      case ($urandom_range(0, 5))
        0: push_item(scf_pkg::CH_STAR);
        1: push_item(scf_pkg::CH_SLASH);
        2: push_item(scf_pkg::CH_LF);
        3: push_text("/*x*/");
        default: push_ord();
      endcase
    end
    if (closed) push_text("*/");
  endtask

  // Gap rates per phase: receiver then sender pressure, then none
  function automatic int idle_pct(input bit recv_side);
    if (acc_cnt >= phase2_at) return 0;
    if (acc_cnt >= phase1_at) return recv_side ? 21 : 81;
    return recv_side ? 81 : 21;
  endfunction

  // ------------------------------------------------------------------------
  // Driver: offers queued requests, changes on the falling edge
  // ------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (src_bytes.size() > 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
        in_data  <= src_bytes.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure plus two long hold-offs
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if ((holds_done == 0 && acc_cnt >= 12) ||
                 (holds_done == 1 && acc_cnt >= phase2_at + 20)) begin
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
    end
  end

  // ------------------------------------------------------------------------
  // Monitor: predicts on accepted input, checks accepted results in order
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    in_took <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        filter_byte(in_data);
        acc_cnt++;
      end
      if (out_valid && out_ready) begin
        res_cnt++;
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected result, byte %0h end %0b",
                                    out_data.out_byte, out_data.is_end));
        end else begin
          want_char = expected_chars.pop_front();
          check_field("out_byte", 32'(out_data.out_byte), 32'(want_char.out_byte));
          check_field("is_end", 32'(out_data.is_end), 32'(want_char.is_end));
          check_field("blank_before", 32'(out_data.blank_before),
                      32'(want_char.blank_before));
          check_field("comment_before", 32'(out_data.comment_before),
                      32'(want_char.comment_before));
          check_field("line_number", 32'(out_data.line_number),
                      32'(want_char.line_number));
          check_field("comment_error", 32'(out_data.comment_error),
                      32'(want_char.comment_error));
          check_field("last_of_run", 32'(out_data.last_of_run),
                      32'(want_char.last_of_run));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, expected_chars.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------------
  initial begin
    reset_filter();

    // Directed: extremes, blanks, newline, continuation over a comment,
    // comma released by a comma, three results from one byte, nesting and
    // an unterminated comment at end of input
    push_item(scf_pkg::CH_NUL);
    push_item(scf_pkg::CH_SPACE);
    push_item(8'hFF);
    push_item(scf_pkg::CH_TAB);
    push_item(scf_pkg::CH_CR);
    push_item(scf_pkg::CH_LF);
    push_text(", /*\n*/\n");
    push_text(",,/x");
    push_text("/*/**/");
    push_item(8'hA5, 1'b1);

    // Random token streams
    rand_start = src_bytes.size();
    while (src_bytes.size() - rand_start < RAND_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        repeat ($urandom_range(1, 5)) push_ord();
      end else if (pick < 32) begin
        repeat ($urandom_range(1, 3)) push_blank();
      end else if (pick < 42) begin
        push_item(scf_pkg::CH_LF);
      end else if (pick < 56) begin
        // comma, look-ahead content, then what decides it
        push_item(scf_pkg::CH_COMMA);
        if ($urandom_range(0, 1)) push_blank();
        if ($urandom_range(0, 2) == 0) push_comment(1'b1);
        if ($urandom_range(0, 2) == 0) push_blank();
        case ($urandom_range(0, 3))
          0, 1: push_item(scf_pkg::CH_LF);
          2: push_ord();
          default: push_item(scf_pkg::CH_COMMA);
        endcase
      end else if (pick < 68) begin
        push_comment(1'b1);
      end else if (pick < 74) begin
        push_item(scf_pkg::CH_SLASH);
        push_ord();
      end else if (pick < 90) begin
        push_item(8'($urandom_range(0, 255)));
      end else if (pick < 96) begin
        if ($urandom_range(0, 1)) push_item(scf_pkg::CH_COMMA);
        if ($urandom_range(0, 1)) push_item(scf_pkg::CH_SLASH);
        push_item(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        push_comment(1'b0);
        push_item(8'($urandom_range(0, 255)), 1'b1);
      end
    end
    phase1_at = rand_start + RAND_ITEMS / 3;
    phase2_at = rand_start + 2 * RAND_ITEMS / 3;

    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Drain: every request sent and every result returned
    while (src_bytes.size() != 0 || in_valid || expected_chars.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Filtered %0d source bytes into %0d checked characters, up to %0d per byte,",
             acc_cnt, res_cnt, peak_res);
    $display("including %0d end markers (%0d inside open comments), %0d mismatches.",
             end_cnt, err_cnt, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
